@@ design/tcrk_pkg.sv @@
// Shared types and constants for the two-compartment release kinetics block.
// No dependencies; every other file of the block refers to this package.
package tcrk_pkg;

	localparam int TIME_FRAC_BITS_DEF = 16;
	localparam int RATE_FRAC_BITS_DEF = 24;

	// exp(-x): Taylor series, then one 1/e multiply per integer unit of x
	localparam int TAYLOR_TERMS   = 15;
	localparam int EXP_POW_STAGES = 31;
	localparam int EXP_LAT        = 3 + 3 * (TAYLOR_TERMS - 1) + EXP_POW_STAGES;
	localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
	localparam logic [30:0] INV_E_Q32 = 31'd1580030169;

	localparam int DIV_STEPS = 32;
	localparam int POST_STAGES = 4;
	localparam int TOTAL_LAT = EXP_LAT + POST_STAGES + DIV_STEPS + 1;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LOADED_AMOUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_RATE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UPTAKE_RATE   = 2'd2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_REQ  = 2'd1,
		ST_CONSERV  = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] elapsed_time;
		logic        activated;
	} req_t;

	typedef struct packed {
		logic [31:0] device_amount;
		logic [31:0] extracellular_amount;
		logic [31:0] intracellular_amount;
		logic [31:0] released_amount;
		status_t     status;
	} res_t;

	// side data that rides along the divider
	typedef struct packed {
		logic        bad;
		logic        act;
		logic [31:0] dev;
		logic [31:0] ext_eq;
		logic        sat;
		logic        dnz;
		logic        dpos;
	} mid_t;

endpackage

@@ design/tcrk_stream_if.sv @@
// Valid/ready stream interfaces for requests and results.
// Depends on tcrk_pkg for the payload types.
interface tcrk_req_if;
	logic             valid;
	logic             ready;
	tcrk_pkg::req_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tcrk_res_if;
	logic             valid;
	logic             ready;
	tcrk_pkg::res_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ design/tcrk_exp.sv @@
// Pipelined exp(-rate*time) in unsigned Q1.32: product, Taylor series, 1/e power chain.
// Depends on tcrk_pkg. Every register stage advances on en.
module tcrk_exp #(
	parameter int TIME_FRAC_BITS = tcrk_pkg::TIME_FRAC_BITS_DEF,
	parameter int RATE_FRAC_BITS = tcrk_pkg::RATE_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] rate,
	input  logic [31:0] tval,
	output logic [32:0] e,
	output logic [4:0]  n,
	output logic [31:0] f
);

	localparam int FB   = TIME_FRAC_BITS + RATE_FRAC_BITS;
	localparam int SH_R = (FB >= 32) ? FB - 32 : 0;
	localparam int SH_L = (FB >= 32) ? 0 : 32 - FB;
	localparam int NT   = tcrk_pkg::TAYLOR_TERMS - 1;
	localparam int NP   = tcrk_pkg::EXP_POW_STAGES;

	typedef struct packed {
		logic [32:0]        term;
		logic [31:0]        p;
		logic [31:0]        q;
		logic [31:0]        f;
		logic [4:0]         n;
		logic               zero;
		logic signed [34:0] sum;
	} tay_t;

	typedef struct packed {
		logic [32:0] e;
		logic [4:0]  n;
		logic [31:0] f;
	} pow_t;

	logic [63:0] prod_s1;
	logic [63:0] nbig;
	logic [63:0] rem;
	tay_t        init;
	tay_t        tay_s[0:3*NT];
	pow_t        clamp;
	pow_t        pow_s[0:NP];

	always_ff @(posedge clk) begin
		if (en) prod_s1 <= 64'(rate) * 64'(tval);
	end

	always_comb begin
		nbig = prod_s1 >> FB;
		rem = prod_s1 - (nbig << FB);
		init.term = tcrk_pkg::ONE_Q32;
		init.p = '0;
		init.q = '0;
		init.zero = |nbig[63:5];
		init.f = init.zero ? 32'd0 : 32'((rem >> SH_R) << SH_L);
		init.n = init.zero ? 5'd0 : nbig[4:0];
		init.sum = 35'sh1_0000_0000;
	end

	always_ff @(posedge clk) begin
		if (en) tay_s[0] <= init;
	end

	genvar g;
	generate
		for (g = 0; g < NT; g++) begin : g_term
			localparam int K = g + 1;
			localparam logic [34:0] RECIP = 35'((64'd1 << 34) / K);
			logic [64:0] pa;
			logic [66:0] pb;
			logic [35:0] qk;
			logic [35:0] rr;
			logic [31:0] nq;
			tay_t        a_nxt;
			tay_t        b_nxt;
			tay_t        c_nxt;

			// term * f, then divide by K with reciprocal and one-step fixup
			always_comb begin
				a_nxt = tay_s[3*g];
				pa = 65'(a_nxt.term) * 65'(a_nxt.f);
				a_nxt.p = pa[63:32];
			end

			always_comb begin
				b_nxt = tay_s[3*g+1];
				pb = 67'(b_nxt.p) * 67'(RECIP);
				b_nxt.q = pb[65:34];
			end

			always_comb begin
				c_nxt = tay_s[3*g+2];
				qk = 36'(c_nxt.q) * 36'(K);
				rr = 36'(c_nxt.p) - qk;
				nq = c_nxt.q + 32'(rr >= 36'(K));
				c_nxt.term = {1'b0, nq};
				if (K % 2 == 1) c_nxt.sum = c_nxt.sum - $signed({3'b000, nq});
				else c_nxt.sum = c_nxt.sum + $signed({3'b000, nq});
			end

			always_ff @(posedge clk) begin
				if (en) begin
					tay_s[3*g+1] <= a_nxt;
					tay_s[3*g+2] <= b_nxt;
					tay_s[3*g+3] <= c_nxt;
				end
			end
		end
	endgenerate

	always_comb begin
		clamp.n = tay_s[3*NT].n;
		clamp.f = tay_s[3*NT].f;
		if (tay_s[3*NT].zero || tay_s[3*NT].sum < 0) clamp.e = '0;
		else if (tay_s[3*NT].sum > 35'sh1_0000_0000) clamp.e = tcrk_pkg::ONE_Q32;
		else clamp.e = tay_s[3*NT].sum[32:0];
	end

	always_ff @(posedge clk) begin
		if (en) pow_s[0] <= clamp;
	end

	genvar j;
	generate
		for (j = 0; j < NP; j++) begin : g_pow
			logic [63:0] pm;
			pow_t        nxt;
			always_comb begin
				nxt = pow_s[j];
				pm = 64'(nxt.e) * 64'(tcrk_pkg::INV_E_Q32);
				if (5'(j) < nxt.n) nxt.e = {1'b0, pm[63:32]};
			end
			always_ff @(posedge clk) begin
				if (en) pow_s[j+1] <= nxt;
			end
		end
	endgenerate

	assign e = pow_s[NP].e;
	assign n = pow_s[NP].n;
	assign f = pow_s[NP].f;

endmodule

@@ design/tcrk_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, side data alongside.
// Depends on tcrk_pkg. Every step advances on en.
module tcrk_div (
	input  logic           clk,
	input  logic           en,
	input  logic [31:0]    dk,
	input  logic [31:0]    rem0,
	input  logic [31:0]    low0,
	input  tcrk_pkg::mid_t side_in,
	output logic [31:0]    quot,
	output tcrk_pkg::mid_t side_out
);

	localparam int NS = tcrk_pkg::DIV_STEPS;

	typedef struct packed {
		logic [31:0] r;
		logic [31:0] low;
		logic [31:0] q;
	} div_t;

	div_t           st_s[0:NS];
	tcrk_pkg::mid_t side_s[0:NS];

	always_comb begin
		st_s[0].r = rem0;
		st_s[0].low = low0;
		st_s[0].q = '0;
		side_s[0] = side_in;
	end

	genvar i;
	generate
		for (i = 0; i < NS; i++) begin : g_step
			logic [32:0] r2;
			logic        ge;
			div_t        nxt;
			always_comb begin
				r2 = {st_s[i].r, st_s[i].low[31]};
				ge = r2 >= {1'b0, dk};
				nxt.r = ge ? 32'(r2 - {1'b0, dk}) : r2[31:0];
				nxt.low = {st_s[i].low[30:0], 1'b0};
				nxt.q = {st_s[i].q[30:0], ge};
			end
			always_ff @(posedge clk) begin
				if (en) begin
					st_s[i+1] <= nxt;
					side_s[i+1] <= side_s[i];
				end
			end
		end
	endgenerate

	assign quot = st_s[NS].q;
	assign side_out = side_s[NS];

endmodule

@@ design/tcrk_out_buf.sv @@
// Two-entry output buffer: decouples the pipeline stall from the result ready.
// Depends on tcrk_pkg and the result stream interface.
module tcrk_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcrk_pkg::res_t data,
	output logic           ready,
	tcrk_res_if.source     res
);

	logic           main_vld_q;
	logic           skid_vld_q;
	tcrk_pkg::res_t main_q;
	tcrk_pkg::res_t skid_q;
	logic           pop;

	assign ready = ~skid_vld_q;
	assign pop = main_vld_q & res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!main_vld_q || pop) begin
			main_vld_q <= skid_vld_q | push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_vld_q || pop) main_q <= skid_vld_q ? skid_q : data;
		else if (push) skid_q <= data;
	end

	assign res.valid = main_vld_q;
	assign res.payload = main_q;

endmodule

@@ design/two_compartment_release_kinetics.sv @@
// Two-compartment release kinetics: device, extracellular, intracellular and
// released amounts for one elapsed time per request. Takes one request every
// cycle unless a full output buffer stalls the pipeline; a result passes 113
// pipeline stages plus the output buffer, set by the 15-term Taylor exp (three
// stages per term after the constant one), the 31-stage 1/e power chain and the 32-stage divider.
module two_compartment_release_kinetics #(
	parameter int TIME_FRAC_BITS = tcrk_pkg::TIME_FRAC_BITS_DEF,
	parameter int RATE_FRAC_BITS = tcrk_pkg::RATE_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [tcrk_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [31:0]                     wr_data,
	tcrk_req_if.sink                        req,
	tcrk_res_if.source                      res
);

	localparam int EL  = tcrk_pkg::EXP_LAT;
	localparam int TOT = tcrk_pkg::TOTAL_LAT;

	typedef struct packed {
		logic bad;
		logic act;
	} ent_t;

	typedef struct packed {
		logic        bad;
		logic        act;
		logic [31:0] dev;
		logic [37:0] ya;
		logic [32:0] yb;
		logic [32:0] d;
		logic        dpos;
	} m1_t;

	typedef struct packed {
		logic        bad;
		logic        act;
		logic [31:0] dev;
		logic [32:0] y;
		logic [63:0] a;
		logic        dnz;
		logic        dpos;
	} m2_t;

	typedef struct packed {
		logic        bad;
		logic        act;
		logic [31:0] dev;
		logic [31:0] ext_eq;
		logic [63:0] plo;
		logic [63:0] phi;
		logic        dnz;
		logic        dpos;
	} m3_t;

	logic [31:0] loaded_q;
	logic [31:0] kr_q;
	logic [31:0] ku_q;
	logic        cfg_bad;
	logic        eq;
	logic        ku_gt;
	logic [31:0] dk;

	logic [TOT-1:0] vld_q;
	logic           adv;
	logic           buf_ready;
	logic           push;

	ent_t        ent_s[0:EL-1];
	logic [32:0] er, eu;
	logic [4:0]  nr, nu;
	logic [31:0] fr, fu;

	m1_t            m1_nxt, mul_s1;
	m2_t            m2_nxt, mul_s2;
	m3_t            m3_nxt, mul_s3;
	tcrk_pkg::mid_t m4_nxt, mul_s4;
	logic [31:0]    rem_s4, low_s4;
	logic [63:0]    a_full, nq;
	logic [64:0]    dev_full, yb_full, ext_full;
	logic [37:0]    ysum;

	logic [31:0]        quot;
	tcrk_pkg::mid_t     dside;
	logic [31:0]        ext_un, ext;
	logic               neg;
	logic signed [33:0] intra;
	tcrk_pkg::res_t     fin_nxt, fin_s;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			kr_q <= 32'(64'd1 << RATE_FRAC_BITS);
			ku_q <= 32'(64'd1 << RATE_FRAC_BITS);
		end else if (wr_en) begin
			case (wr_index)
				tcrk_pkg::REG_LOADED_AMOUNT: loaded_q <= wr_data;
				tcrk_pkg::REG_RELEASE_RATE:  kr_q <= wr_data;
				tcrk_pkg::REG_UPTAKE_RATE:   ku_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg_bad = (loaded_q == '0) | (kr_q == '0) | (ku_q == '0);
	assign eq = kr_q == ku_q;
	assign ku_gt = ku_q > kr_q;
	assign dk = ku_gt ? ku_q - kr_q : kr_q - ku_q;

	// whole pipeline moves together; stalls only when the buffer is full
	assign adv = buf_ready | ~vld_q[TOT-1];
	assign req.ready = adv;
	assign push = vld_q[TOT-1] & buf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[TOT-2:0], req.valid};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s[0].bad <= cfg_bad | (req.payload.elapsed_time == '0);
			ent_s[0].act <= req.payload.activated;
			for (int k = 1; k < EL; k++) ent_s[k] <= ent_s[k-1];
		end
	end

	tcrk_exp #(
		.TIME_FRAC_BITS(TIME_FRAC_BITS),
		.RATE_FRAC_BITS(RATE_FRAC_BITS)
	) u_exp_r (
		.clk(clk), .en(adv), .rate(kr_q), .tval(req.payload.elapsed_time),
		.e(er), .n(nr), .f(fr)
	);

	tcrk_exp #(
		.TIME_FRAC_BITS(TIME_FRAC_BITS),
		.RATE_FRAC_BITS(RATE_FRAC_BITS)
	) u_exp_u (
		.clk(clk), .en(adv), .rate(ku_q), .tval(req.payload.elapsed_time),
		.e(eu), .n(nu), .f(fu)
	);

	// stage 1: device amount, equal-rate terms of x*exp(-x), exp difference
	always_comb begin
		m1_nxt.bad = ent_s[EL-1].bad;
		m1_nxt.act = ent_s[EL-1].act;
		dev_full = 65'(loaded_q) * 65'(er);
		m1_nxt.dev = dev_full[63:32];
		m1_nxt.ya = 38'(nr) * 38'(er);
		yb_full = 65'(fr) * 65'(er);
		m1_nxt.yb = yb_full[64:32];
		m1_nxt.dpos = er >= eu;
		m1_nxt.d = m1_nxt.dpos ? er - eu : eu - er;
	end

	// stage 2
	always_comb begin
		m2_nxt.bad = mul_s1.bad;
		m2_nxt.act = mul_s1.act;
		m2_nxt.dev = mul_s1.dev;
		ysum = mul_s1.ya + 38'(mul_s1.yb);
		m2_nxt.y = (ysum > 38'(tcrk_pkg::ONE_Q32)) ? tcrk_pkg::ONE_Q32 : ysum[32:0];
		a_full = 64'(loaded_q) * 64'(mul_s1.d);
		m2_nxt.a = a_full;
		m2_nxt.dnz = mul_s1.d != '0;
		m2_nxt.dpos = mul_s1.dpos;
	end

	// stage 3: equal-rate extracellular amount, L*d*kr as two partial products
	always_comb begin
		m3_nxt.bad = mul_s2.bad;
		m3_nxt.act = mul_s2.act;
		m3_nxt.dev = mul_s2.dev;
		ext_full = 65'(loaded_q) * 65'(mul_s2.y);
		m3_nxt.ext_eq = ext_full[63:32];
		m3_nxt.plo = 64'(mul_s2.a[31:0]) * 64'(kr_q);
		m3_nxt.phi = 64'(mul_s2.a[63:32]) * 64'(kr_q);
		m3_nxt.dnz = mul_s2.dnz;
		m3_nxt.dpos = mul_s2.dpos;
	end

	// stage 4: numerator / 2^32; quotient saturates when high word >= dk
	always_comb begin
		nq = mul_s3.phi + 64'(mul_s3.plo[63:32]);
		m4_nxt.bad = mul_s3.bad;
		m4_nxt.act = mul_s3.act;
		m4_nxt.dev = mul_s3.dev;
		m4_nxt.ext_eq = mul_s3.ext_eq;
		m4_nxt.sat = nq[63:32] >= dk;
		m4_nxt.dnz = mul_s3.dnz;
		m4_nxt.dpos = mul_s3.dpos;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s1 <= m1_nxt;
			mul_s2 <= m2_nxt;
			mul_s3 <= m3_nxt;
			mul_s4 <= m4_nxt;
			rem_s4 <= nq[63:32];
			low_s4 <= nq[31:0];
		end
	end

	tcrk_div u_div (
		.clk(clk), .en(adv), .dk(dk), .rem0(rem_s4), .low0(low_s4),
		.side_in(mul_s4), .quot(quot), .side_out(dside)
	);

	// final stage: pick extracellular, form remainder and status
	always_comb begin
		ext_un = dside.sat ? '1 : quot;
		neg = ~eq & dside.dnz & (dside.dpos != ku_gt);
		ext = eq ? dside.ext_eq : (neg ? 32'd0 : ext_un);
		intra = $signed({2'b00, loaded_q}) - $signed({2'b00, dside.dev})
			- $signed({2'b00, ext});
		fin_nxt.device_amount = dside.dev;
		fin_nxt.extracellular_amount = ext;
		fin_nxt.intracellular_amount = (intra < 0) ? 32'd0 : intra[31:0];
		fin_nxt.released_amount = loaded_q - dside.dev;
		fin_nxt.status = (neg || intra < 0) ? tcrk_pkg::ST_CONSERV : tcrk_pkg::ST_OK;
		if (dside.bad) begin
			fin_nxt = '0;
			fin_nxt.status = tcrk_pkg::ST_BAD_REQ;
		end else if (!dside.act) begin
			fin_nxt = '0;
			fin_nxt.device_amount = loaded_q;
			fin_nxt.status = tcrk_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) fin_s <= fin_nxt;
	end

	tcrk_out_buf u_out_buf (
		.clk(clk), .arst_n(arst_n), .push(push), .data(fin_s),
		.ready(buf_ready), .res(res)
	);

endmodule
